@@ rtl/pts_pkg.sv @@
package pts_pkg;

   localparam int TICK_W    = 32;
   localparam int RUN_W     = 32;
   localparam int PRIO_W    = 8;
   localparam int RSP_IDX_W = 4;

   typedef enum logic [1:0] {
      REQ_TICK,
      REQ_CREATE,
      REQ_SLEEP,
      REQ_SCHED
   } req_code_type;

   typedef enum logic [1:0] {
      RSP_OK,
      RSP_FULL,
      RSP_NO_CURRENT,
      RSP_NO_TASK
   } rsp_status_type;

   typedef enum logic [1:0] {
      TS_READY,
      TS_RUNNING,
      TS_SLEEPING
   } task_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLEEP,
      ST_SCAN,
      ST_DEMOTE,
      ST_PROMOTE
   } state_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      task_state_type    status;
      logic [TICK_W-1:0] wake;
      logic [RUN_W-1:0]  runs;
   } entry_type;

   typedef struct packed {
      entry_type word;
      logic      woke;
      logic      eligible;
   } tbl_rd_type;

endpackage

@@ rtl/pts_table.sv @@
module pts_table
   import pts_pkg::*;
#(
   parameter int TASK_SLOTS = 16,
   parameter int IDX_W      = 4
) (
   input  logic              clock,
   input  logic [IDX_W-1:0]  rd_addr,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  entry_type         wr_data,
   input  logic [TICK_W-1:0] tick,
   output tbl_rd_type        rd
);

   entry_type entry_ff [TASK_SLOTS];
   entry_type q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      q_ff <= entry_ff[rd_addr];
   end

   // sleeper whose deadline has passed reads back as ready
   always_comb begin
      rd.word = q_ff;
      rd.woke = (q_ff.status == TS_SLEEPING) && (tick >= q_ff.wake);
      if (rd.woke) begin
         rd.word.status = TS_READY;
      end
      rd.eligible = (rd.word.status == TS_READY) || (rd.word.status == TS_RUNNING);
   end

endmodule

@@ rtl/priority_task_scheduler.sv @@
// Fixed-priority task scheduler with a table of up to TASK_SLOTS tasks held in one
// synchronous memory. A transaction is taken when start is high and busy is low, and
// its single result shows on the rsp_ ports for one cycle with rsp_strobe; the receiver
// cannot stall it. Tick, create and every rejected request raise no busy and give their
// result in the cycle after acceptance. Sleep does one memory read, then one write.
// Schedule reads the whole table before giving its result: the single memory read
// port visits one table entry per cycle, newest first, followed by one write state to
// demote the old running task and one to promote the chosen one, if any is eligible.
// A new transaction may be started in the cycle in which the result is shown.
module priority_task_scheduler
   import pts_pkg::*;
#(
   parameter int TASK_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [PRIO_W-1:0] req_priority_req,
   input  logic [TICK_W-1:0] req_sleep_ticks,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [RSP_IDX_W-1:0] rsp_task_index,
   output logic [RUN_W-1:0]  rsp_task_run_count,
   output logic [TICK_W-1:0] rsp_tick_now
);

   localparam int IDX_W = $clog2(TASK_SLOTS);
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W-1:0] sleep_ff, sleep_in;

   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              issue_ff, issue_in;
   logic              rd_v_ff, rd_v_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   entry_type         best_word_ff, best_word_in;
   entry_type         cur_word_ff, cur_word_in;
   entry_type         newest_word_ff, newest_word_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_status_type    rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [RUN_W-1:0]  rsp_runs_ff, rsp_runs_in;

   logic              accept;
   req_code_type      req_code;
   logic              full;
   logic [CNT_W-1:0]  cnt_m1;
   logic [IDX_W-1:0]  last_idx;
   logic [TICK_W-1:0] wake_sum;
   logic              demote_need;
   logic [IDX_W+RSP_IDX_W-1:0] idx_ext;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic [IDX_W-1:0]  rd_addr;
   tbl_rd_type        tbl;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign req_code = req_code_type'(req_type);
   assign full     = (count_ff == CNT_W'(TASK_SLOTS));
   assign cnt_m1   = count_ff - CNT_W'(1);
   assign last_idx = cnt_m1[IDX_W-1:0];
   assign wake_sum = tick_ff + sleep_ff;
   assign rd_addr  = (state_ff == ST_SCAN) ? scan_ff : cur_ff;

   assign demote_need = cur_valid_ff && (cur_word_ff.status == TS_RUNNING) &&
                        !(found_ff && (best_ff == cur_ff));

   pts_table #(
      .TASK_SLOTS (TASK_SLOTS),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .tick    (tick_ff),
      .rd      (tbl)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_code == REQ_SLEEP && cur_valid_ff) begin
                  state_in = ST_SLEEP;
               end else if (req_code == REQ_SCHED && count_ff != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SLEEP:   state_in = ST_IDLE;
         ST_SCAN: begin
            if (rd_v_ff && rd_idx_ff == '0) begin
               state_in = ST_DEMOTE;
            end
         end
         ST_DEMOTE:  state_in = ST_PROMOTE;
         ST_PROMOTE: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = tbl.word;
      count_in       = count_ff;
      cur_in         = cur_ff;
      cur_valid_in   = cur_valid_ff;
      tick_in        = tick_ff;
      sleep_in       = sleep_ff;
      scan_in        = scan_ff;
      issue_in       = issue_ff;
      rd_v_in        = 1'b0;
      rd_idx_in      = scan_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_word_in   = best_word_ff;
      cur_word_in    = cur_word_ff;
      newest_word_in = newest_word_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = RSP_OK;
      rsp_idx_in     = '0;
      rsp_runs_in    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_code)
                  REQ_TICK: begin
                     tick_in       = tick_ff + TICK_W'(1);
                     rsp_strobe_in = 1'b1;
                  end
                  REQ_CREATE: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_status_in = RSP_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        wr_addr        = count_ff[IDX_W-1:0];
                        wr_data.prio   = req_priority_req;
                        wr_data.status = TS_READY;
                        wr_data.wake   = '0;
                        wr_data.runs   = '0;
                        count_in       = count_ff + CNT_W'(1);
                        rsp_idx_in     = count_ff[IDX_W-1:0];
                     end
                  end
                  REQ_SLEEP: begin
                     sleep_in = req_sleep_ticks;
                     if (!cur_valid_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = RSP_NO_CURRENT;
                     end
                  end
                  REQ_SCHED: begin
                     if (count_ff == '0) begin
                        cur_valid_in  = 1'b0;
                        cur_in        = '0;
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = RSP_NO_TASK;
                     end else begin
                        scan_in  = last_idx;
                        issue_in = 1'b1;
                        found_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SLEEP: begin
            wr_en          = 1'b1;
            wr_addr        = cur_ff;
            wr_data.status = TS_SLEEPING;
            wr_data.wake   = wake_sum;
            rsp_strobe_in  = 1'b1;
            rsp_idx_in     = cur_ff;
            rsp_runs_in    = tbl.word.runs;
         end
         ST_SCAN: begin
            if (issue_ff) begin
               rd_v_in   = 1'b1;
               rd_idx_in = scan_ff;
               scan_in   = scan_ff - IDX_W'(1);
               if (scan_ff == '0) begin
                  issue_in = 1'b0;
               end
            end
            if (rd_v_ff) begin
               if (tbl.woke) begin
                  wr_en   = 1'b1;
                  wr_addr = rd_idx_ff;
               end
               // newest first, strict compare keeps the newest on a tie
               if (tbl.eligible && (!found_ff || tbl.word.prio > best_word_ff.prio)) begin
                  found_in     = 1'b1;
                  best_in      = rd_idx_ff;
                  best_word_in = tbl.word;
               end
               if (rd_idx_ff == cur_ff) begin
                  cur_word_in = tbl.word;
               end
               if (rd_idx_ff == last_idx) begin
                  newest_word_in = tbl.word;
               end
            end
         end
         ST_DEMOTE: begin
            if (demote_need) begin
               wr_en          = 1'b1;
               wr_addr        = cur_ff;
               wr_data        = cur_word_ff;
               wr_data.status = TS_READY;
            end
         end
         ST_PROMOTE: begin
            cur_valid_in  = 1'b1;
            rsp_strobe_in = 1'b1;
            if (found_ff) begin
               wr_en          = 1'b1;
               wr_addr        = best_ff;
               wr_data        = best_word_ff;
               wr_data.status = TS_RUNNING;
               wr_data.runs   = best_word_ff.runs + RUN_W'(1);
               cur_in         = best_ff;
               rsp_idx_in     = best_ff;
               rsp_runs_in    = best_word_ff.runs + RUN_W'(1);
            end else begin
               cur_in      = last_idx;
               rsp_idx_in  = last_idx;
               rsp_runs_in = newest_word_ff.runs;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cur_ff        <= '0;
         cur_valid_ff  <= 1'b0;
         tick_ff       <= '0;
         issue_ff      <= 1'b0;
         rd_v_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cur_ff        <= cur_in;
         cur_valid_ff  <= cur_valid_in;
         tick_ff       <= tick_in;
         issue_ff      <= issue_in;
         rd_v_ff       <= rd_v_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sleep_ff       <= sleep_in;
      scan_ff        <= scan_in;
      rd_idx_ff      <= rd_idx_in;
      best_ff        <= best_in;
      best_word_ff   <= best_word_in;
      cur_word_ff    <= cur_word_in;
      newest_word_ff <= newest_word_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_runs_ff    <= rsp_runs_in;
   end

   assign idx_ext            = {{RSP_IDX_W{1'b0}}, rsp_idx_ff};
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_task_index     = idx_ext[RSP_IDX_W-1:0];
   assign rsp_task_run_count = rsp_runs_ff;
   assign rsp_tick_now       = tick_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TASK_SLOTS))
      else $error("task count above table size");

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (CNT_W'(cur_ff) < count_ff))
      else $error("current task outside table");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("accepted transaction neither answered nor in progress");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("result shown while busy");

   a_promote_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROMOTE) |=> (rsp_strobe && cur_valid_ff))
      else $error("schedule finished without result");

endmodule
